@@ design/fppc_pkg.sv @@
// shared types, constants and helpers for the frame phase performance counters
// no dependencies
package fppc_pkg;

  localparam int TIME_BITS  = 64;
  localparam int COUNT_BITS = 32;
  localparam int DIV_BITS   = 64;
  localparam int DCNT_BITS  = $clog2(DIV_BITS + 1);

  localparam logic [31:0] THRESHOLD_RESET = 32'd50;
  localparam logic [31:0] SAT32           = 32'hFFFF_FFFF;
  localparam logic [9:0]  KILO            = 10'd1000;
  localparam logic [3:0]  TEN             = 4'd10;

  typedef enum logic [3:0] {
    FN_REFRESH_START = 4'd0,
    FN_REFRESH_DONE  = 4'd1,
    FN_RENDER_START  = 4'd2,
    FN_RENDER_DONE   = 4'd3,
    FN_FLUSH_START   = 4'd4,
    FN_FLUSH_DONE    = 4'd5,
    FN_WAIT_START    = 4'd6,
    FN_WAIT_DONE     = 4'd7,
    FN_REPORT        = 4'd8
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVENT,
    ST_KPIX_MUL,
    ST_KPIX_DIV,
    ST_STRIP_DIV,
    ST_AVG_DIV,
    ST_EMIT,
    ST_CLEAR
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       apply_event;
    logic       kpix_mul;
    logic       div_start;
    logic [1:0] div_sel;   // 0 kpix, 1 strips, 2 average
    logic [1:0] phase;
    logic       latch_now; // keep the report timestamp
    logic       load_out;
    logic       clear;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
  } status_t;

endpackage

@@ design/fppc_divider.sv @@
// shared restoring divider, one quotient bit per cycle
// depends on fppc_pkg
module fppc_divider
  import fppc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [DIV_BITS-1:0] dividend,
  input  logic [DIV_BITS-1:0] divisor,
  output logic [DIV_BITS-1:0] quotient,
  output logic                busy,
  output logic                done
);

  logic [DIV_BITS-1:0]  rem;
  logic [DIV_BITS-1:0]  den;
  logic [DCNT_BITS-1:0] cnt;
  logic [DIV_BITS:0]    trial;

  assign trial = {rem, quotient[DIV_BITS-1]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        quotient <= dividend;
        rem      <= '0;
        den      <= divisor;
        cnt      <= DCNT_BITS'(DIV_BITS);
      end else if (busy) begin
        if (!trial[DIV_BITS]) begin
          rem      <= trial[DIV_BITS-1:0];
          quotient <= {quotient[DIV_BITS-2:0], 1'b1};
        end else begin
          rem      <= {rem[DIV_BITS-2:0], quotient[DIV_BITS-1]};
          quotient <= {quotient[DIV_BITS-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == DCNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ design/fppc_datapath.sv @@
// counter registers, event arithmetic, report assembly
// depends on fppc_pkg and fppc_divider
module fppc_datapath
  import fppc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     status,
  input  logic [3:0]  func,
  input  logic [62:0] timestamp_us,
  input  logic [23:0] pixel_count,
  input  logic [31:0] threshold,
  output logic [1:0]  out_category,
  output logic [31:0] out_count,
  output logic [31:0] out_avg,
  output logic [31:0] out_max,
  output logic [31:0] out_blocked,
  output logic [63:0] out_kpix,
  output logic [31:0] out_strips,
  output logic        out_last
);

  logic [TIME_BITS-1:0]  start_time [4];
  logic [TIME_BITS-1:0]  total      [4];
  logic [31:0]           maximum    [4];
  logic [COUNT_BITS-1:0] count      [4];
  logic [COUNT_BITS-1:0] blocked;
  logic [63:0]           pixels;
  logic [TIME_BITS-1:0]  win_start;
  logic [TIME_BITS-1:0]  rpt_now;
  logic [63:0]           kpix_prod;
  logic [63:0]           kpix;
  logic [31:0]           strips;
  logic [31:0]           avg;

  logic [TIME_BITS-1:0] now;
  logic [1:0]           ph;
  logic [TIME_BITS-1:0] diff;
  logic [31:0]          elapsed;
  logic [TIME_BITS-1:0] wdiff;
  logic [TIME_BITS-1:0] win;

  logic [DIV_BITS-1:0] dvd, dvs, quo;

  assign now  = TIME_BITS'({1'b0, timestamp_us});
  assign ph   = func[2:1];
  assign diff = now - start_time[ph];
  assign elapsed = (diff[TIME_BITS-1]) ? 32'd0 :
                   (|(diff >> 32)) ? SAT32 : diff[31:0];
  assign wdiff = rpt_now - win_start;
  assign win   = (wdiff[TIME_BITS-1] || wdiff == '0) ? TIME_BITS'(1) : wdiff;

  always_comb begin
    case (cmd.div_sel)
      2'd0: begin
        dvd = kpix_prod;
        dvs = DIV_BITS'(win);
      end
      2'd1: begin
        dvd = DIV_BITS'(count[2]) * DIV_BITS'(TEN);
        dvs = DIV_BITS'(count[1]);
      end
      default: begin
        dvd = DIV_BITS'(total[cmd.phase]);
        dvs = DIV_BITS'(count[cmd.phase]);
      end
    endcase
  end

  fppc_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .quotient (quo),
    .busy     (status.div_busy),
    .done     (status.div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        start_time[i] <= '0;
        total[i]      <= '0;
        maximum[i]    <= '0;
        count[i]      <= '0;
      end
      blocked   <= '0;
      pixels    <= '0;
      win_start <= '0;
    end else if (cmd.clear) begin
      for (int i = 0; i < 4; i++) begin
        total[i]   <= '0;
        maximum[i] <= '0;
        count[i]   <= '0;
      end
      blocked   <= '0;
      pixels    <= '0;
      win_start <= rpt_now;
    end else if (cmd.apply_event) begin
      case (func)
        FN_REFRESH_START, FN_RENDER_START, FN_WAIT_START: begin
          start_time[ph] <= now;
        end
        FN_FLUSH_START: begin
          start_time[2] <= now;
          pixels        <= pixels + 64'(pixel_count);
          count[2]      <= count[2] + 1'b1;
        end
        FN_REFRESH_DONE, FN_RENDER_DONE, FN_FLUSH_DONE, FN_WAIT_DONE: begin
          total[ph] <= total[ph] + TIME_BITS'(elapsed);
          if (elapsed > maximum[ph]) maximum[ph] <= elapsed;
          if (func != FN_FLUSH_DONE) count[ph] <= count[ph] + 1'b1;
          if (func == FN_WAIT_DONE && elapsed >= threshold) blocked <= blocked + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_now) rpt_now <= now;
    if (cmd.kpix_mul) kpix_prod <= pixels * 64'(KILO);
    if (status.div_done) begin
      case (cmd.div_sel)
        2'd0:    kpix <= quo;
        2'd1:    strips <= (count[1] == '0) ? 32'd0 : (|quo[63:32]) ? SAT32 : quo[31:0];
        default: avg <= (count[cmd.phase] == '0) ? 32'd0 :
                        (|quo[63:32]) ? SAT32 : quo[31:0];
      endcase
    end
    if (cmd.load_out) begin
      out_category <= cmd.phase;
      out_count    <= 32'(count[cmd.phase]);
      out_avg      <= avg;
      out_max      <= maximum[cmd.phase];
      out_blocked  <= 32'(blocked);
      out_kpix     <= kpix;
      out_strips   <= strips;
      out_last     <= (cmd.phase == 2'd3);
    end
  end

endmodule

@@ design/fppc_ctrl.sv @@
// sequencer for events and report division steps
// depends on fppc_pkg
module fppc_ctrl
  import fppc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [3:0] func,
  output logic       out_valid,
  input  logic       out_ready,
  output cmd_t       cmd,
  input  status_t    status
);

  state_t     state, state_next;
  logic [1:0] phase, phase_next;
  logic       started, started_next;
  logic       ovalid, ovalid_next;

  assign out_valid = ovalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      phase   <= '0;
      started <= 1'b0;
      ovalid  <= 1'b0;
    end else begin
      state   <= state_next;
      phase   <= phase_next;
      started <= started_next;
      ovalid  <= ovalid_next;
    end
  end

  always_comb begin
    state_next   = state;
    phase_next   = phase;
    started_next = started;
    ovalid_next  = ovalid;
    cmd          = '0;
    cmd.phase    = phase;
    in_ready     = 1'b0;
    if (ovalid && out_ready) ovalid_next = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (func == FN_REPORT) begin
            cmd.latch_now = 1'b1;
            state_next    = ST_KPIX_MUL;
          end else begin
            cmd.apply_event = 1'b1;
          end
        end
      end
      ST_KPIX_MUL: begin
        cmd.kpix_mul = 1'b1;
        state_next   = ST_KPIX_DIV;
        started_next = 1'b0;
      end
      ST_KPIX_DIV: begin
        cmd.div_sel = 2'd0;
        if (!started) begin
          cmd.div_start = 1'b1;
          started_next  = 1'b1;
        end else if (status.div_done) begin
          started_next = 1'b0;
          state_next   = ST_STRIP_DIV;
        end
      end
      ST_STRIP_DIV: begin
        cmd.div_sel = 2'd1;
        if (!started) begin
          cmd.div_start = 1'b1;
          started_next  = 1'b1;
        end else if (status.div_done) begin
          started_next = 1'b0;
          phase_next   = '0;
          state_next   = ST_AVG_DIV;
        end
      end
      ST_AVG_DIV: begin
        cmd.div_sel = 2'd2;
        if (!started) begin
          cmd.div_start = 1'b1;
          started_next  = 1'b1;
        end else if (status.div_done) begin
          started_next = 1'b0;
          state_next   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.div_sel = 2'd2;
        if (!ovalid || out_ready) begin
          cmd.load_out = 1'b1;
          ovalid_next  = 1'b1;
          if (phase == 2'd3) begin
            state_next = ST_CLEAR;
          end else begin
            phase_next = phase + 1'b1;
            state_next = ST_AVG_DIV;
          end
        end
      end
      ST_CLEAR: begin
        cmd.clear  = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/frame_phase_perf_counters.sv @@
// top level of the frame phase performance counters
// depends on fppc_pkg, fppc_ctrl, fppc_datapath
//
// Display-pipeline event counters. Ordinary events (phase start/finish, flush start,
// unused codes) are taken in one cycle each, back to back. A report request runs a shared
// 64-bit restoring divider six times (kilopixel rate, strips per redraw, four averages),
// each run waiting on the divider from start to result; with the product step, four
// output loads and the clear, plus any output stall, a report keeps the input closed
// from when it is taken until all of these are done. The four result items leave
// through a registered output while the next average is computed; the last one may still
// wait there while new events are taken. The report timestamp is latched when the request
// is taken. The blocked threshold may be written whenever no report is in flight.
module frame_phase_perf_counters
  import fppc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  // func[3:0], timestamp_us[66:4], pixel_count[90:67], zero fill
  input  logic [95:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // category[1:0], event_count[33:2], mean_us[65:34], maximum_us[97:66],
  // blocked_count[129:98], kilo_pixels_per_s[193:130], strips_x10[225:194], zero fill
  output logic [231:0] m_tdata,
  output logic         m_tlast
);

  logic [31:0] threshold;
  cmd_t        cmd;
  status_t     status;
  logic [1:0]  o_cat;
  logic [31:0] o_cnt, o_avg, o_max, o_blk, o_str;
  logic [63:0] o_kpix;

  // blocked threshold register
  always_ff @(posedge clk) begin
    if (rst) threshold <= THRESHOLD_RESET;
    else if (cfg_we) threshold <= cfg_wdata;
  end

  fppc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .func      (s_tdata[3:0]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd),
    .status    (status)
  );

  fppc_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .func         (s_tdata[3:0]),
    .timestamp_us (s_tdata[66:4]),
    .pixel_count  (s_tdata[90:67]),
    .threshold    (threshold),
    .out_category (o_cat),
    .out_count    (o_cnt),
    .out_avg      (o_avg),
    .out_max      (o_max),
    .out_blocked  (o_blk),
    .out_kpix     (o_kpix),
    .out_strips   (o_str),
    .out_last     (m_tlast)
  );

  assign m_tdata = {6'd0, o_str, o_kpix, o_blk, o_max, o_avg, o_cnt, o_cat};

endmodule

@@ dv/tb_frame_phase_perf_counters.sv @@
// self-checking testbench for the frame phase performance counters
// depends on fppc_pkg and frame_phase_perf_counters
`timescale 1ns / 100ps

typedef struct packed {
  logic [1:0]  category;
  logic [31:0] event_count;
  logic [31:0] mean_us;
  logic [31:0] maximum_us;
  logic [31:0] blocked_count;
  logic [63:0] kilo_pixels_per_s;
  logic [31:0] strips_x10;
  logic        last;
} phase_report_t;

class phase_report_board;
  logic [63:0] start_time [4];
  logic [63:0] total [4];
  logic [31:0] maximum [4];
  logic [31:0] count [4];
  logic [31:0] blocked;
  logic [63:0] pixels;
  logic [63:0] window_start;
  logic [31:0] threshold;
  phase_report_t pending_reports [$];
  int errors;

  function new();
    for (int p = 0; p < 4; p++) begin
      start_time[p] = 0;
    end
    clear_window(64'd0);
    threshold = 32'd50;
    errors = 0;
  endfunction

  function void clear_window(logic [63:0] now);
    for (int p = 0; p < 4; p++) begin
      total[p] = 0;
      maximum[p] = 0;
      count[p] = 0;
    end
    blocked = 0;
    pixels = 0;
    window_start = now;
  endfunction

  // elapsed time, zero when time runs backwards
  function logic [63:0] elapsed(logic [63:0] now, logic [63:0] since);
    logic [63:0] d;
    d = now - since;
    return d[63] ? 64'd0 : d;
  endfunction

  function logic [31:0] sat32(logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function logic [31:0] finish_phase(int p, logic [63:0] now);
    logic [31:0] e;
    e = sat32(elapsed(now, start_time[p]));
    total[p] += {32'd0, e};
    if (e > maximum[p]) maximum[p] = e;
    return e;
  endfunction

  function void note_event(logic [3:0] fn, logic [62:0] ts, logic [23:0] pix);
    logic [63:0] now, win, kpix, strips;
    logic [31:0] e;
    phase_report_t r;
    now = {1'b0, ts};
    case (fn)
      fppc_pkg::FN_REFRESH_START: start_time[0] = now;
      fppc_pkg::FN_RENDER_START:  start_time[1] = now;
      fppc_pkg::FN_WAIT_START:    start_time[3] = now;
      fppc_pkg::FN_FLUSH_START: begin
        start_time[2] = now;
        pixels += {40'd0, pix};
        count[2]++;
      end
      fppc_pkg::FN_REFRESH_DONE: begin
        e = finish_phase(0, now);
        count[0]++;
      end
      fppc_pkg::FN_RENDER_DONE: begin
        e = finish_phase(1, now);
        count[1]++;
      end
      fppc_pkg::FN_FLUSH_DONE: e = finish_phase(2, now);
      fppc_pkg::FN_WAIT_DONE: begin
        e = finish_phase(3, now);
        count[3]++;
        if (e >= threshold) blocked++;
      end
      fppc_pkg::FN_REPORT: begin
        win = elapsed(now, window_start);
        if (win == 0) win = 1;
        kpix = (pixels * 64'd1000) / win;
        strips = 0;
        if (count[1] != 0) strips = ({32'd0, count[2]} * 64'd10) / {32'd0, count[1]};
        for (int p = 0; p < 4; p++) begin
          r.category = p[1:0];
          r.event_count = count[p];
          r.mean_us = (count[p] != 0) ? sat32(total[p] / {32'd0, count[p]}) : 32'd0;
          r.maximum_us = maximum[p];
          r.blocked_count = blocked;
          r.kilo_pixels_per_s = kpix;
          r.strips_x10 = sat32(strips);
          r.last = (p == 3);
          pending_reports.push_back(r);
        end
        clear_window(now);
      end
      default: ;
    endcase
  endfunction

  function void check_report(phase_report_t got);
    phase_report_t exp;
    if (pending_reports.size() == 0) begin
      $display("%0t: unexpected report item %h", $time, got);
      errors++;
      return;
    end
    exp = pending_reports.pop_front();
    if (got.category != exp.category)
      $display("%0t: category exp %0d got %0d", $time, exp.category, got.category);
    if (got.event_count != exp.event_count)
      $display("%0t: event_count exp %0d got %0d", $time, exp.event_count, got.event_count);
    if (got.mean_us != exp.mean_us)
      $display("%0t: mean_us exp %0d got %0d", $time, exp.mean_us, got.mean_us);
    if (got.maximum_us != exp.maximum_us)
      $display("%0t: maximum_us exp %0d got %0d", $time, exp.maximum_us, got.maximum_us);
    if (got.blocked_count != exp.blocked_count)
      $display("%0t: blocked_count exp %0d got %0d", $time, exp.blocked_count,
               got.blocked_count);
    if (got.kilo_pixels_per_s != exp.kilo_pixels_per_s)
      $display("%0t: kilo_pixels_per_s exp %0d got %0d", $time, exp.kilo_pixels_per_s,
               got.kilo_pixels_per_s);
    if (got.strips_x10 != exp.strips_x10)
      $display("%0t: strips_x10 exp %0d got %0d", $time, exp.strips_x10, got.strips_x10);
    if (got.last != exp.last)
      $display("%0t: last exp %0d got %0d", $time, exp.last, got.last);
    if (got != exp) errors++;
  endfunction
endclass

module tb_frame_phase_perf_counters;
  import fppc_pkg::*;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [31:0]  cfg_wdata = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [95:0]  s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [231:0] m_tdata;
  logic         m_tlast;

  phase_report_board board = new();

  // long sink hold-off: requested by the stimulus, counted by the sink process
  bit          hold_req = 1'b0;
  bit          hold_seen = 1'b0;
  bit          sink_random = 1'b1;
  longint      cycles = 0;
  logic [62:0] clock_us = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  frame_phase_perf_counters dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  // generous watchdog, allowing for report time plus stalls
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 1500000) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side: score each accepted item, then, if sink_random is set, pause ready at random before the next
  initial begin : sink
    int gap_left;
    int hold_left;
    phase_report_t got;
    gap_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got = {m_tdata[1:0], m_tdata[33:2], m_tdata[65:34], m_tdata[97:66],
               m_tdata[129:98], m_tdata[193:130], m_tdata[225:194], m_tlast};
        board.check_report(got);
        gap_left = sink_random ? int'($urandom_range(0, 19)) : 0;
      end
      if (hold_req && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // one request, after the given gap, held until taken
  task automatic send_event(logic [3:0] fn, logic [62:0] ts, logic [23:0] pix, int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'd0, pix, ts, fn};
    do @(posedge clk); while (!s_tready);
    board.note_event(fn, ts, pix);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (board.pending_reports.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
  endtask

  task automatic write_threshold(logic [31:0] value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.threshold = value;
  endtask

  // mostly forward-moving time with occasional jumps back or far ahead
  function automatic logic [62:0] next_time();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) clock_us = 63'({$urandom, $urandom});
    else if (sel == 1) clock_us = clock_us - 63'($urandom_range(1, 1000));
    else if (sel == 2)
      clock_us = clock_us + 63'({$urandom, $urandom} >> $urandom_range(0, 31));
    else clock_us = clock_us + 63'($urandom_range(0, 200));
    return clock_us;
  endfunction

  function automatic logic [23:0] random_pixels();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 24'd0;
    if (sel == 1) return 24'hFFFFFF;
    return 24'($urandom);
  endfunction

  task automatic random_frame(int gap_max);
    logic [3:0] fn;
    if ($urandom_range(0, 9) == 0) begin
      // noise, including unused codes
      fn = 4'($urandom);
      send_event(fn, next_time(), random_pixels(), $urandom_range(0, gap_max));
    end else begin
      send_event(FN_REFRESH_START, next_time(), 24'd0, $urandom_range(0, gap_max));
      send_event(FN_RENDER_START, next_time(), 24'd0, $urandom_range(0, gap_max));
      send_event(FN_RENDER_DONE, next_time(), 24'd0, $urandom_range(0, gap_max));
      send_event(FN_FLUSH_START, next_time(), random_pixels(), $urandom_range(0, gap_max));
      send_event(FN_WAIT_START, next_time(), 24'd0, $urandom_range(0, gap_max));
      send_event(FN_WAIT_DONE, next_time(), 24'd0, $urandom_range(0, gap_max));
      send_event(FN_FLUSH_DONE, next_time(), 24'd0, $urandom_range(0, gap_max));
      send_event(FN_REFRESH_DONE, next_time(), 24'd0, $urandom_range(0, gap_max));
      if ($urandom_range(0, 3) == 0)
        send_event(FN_REPORT, next_time(), 24'd0, $urandom_range(0, gap_max));
    end
  endtask

  initial begin : stimulus
    int sent;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: finishes without start, empty window, backwards and huge times
    send_event(FN_REFRESH_DONE, 63'd100, 24'd0, 0);
    send_event(FN_REPORT, 63'd0, 24'd0, 0);
    send_event(FN_REPORT, 63'd0, 24'd0, 0);
    send_event(FN_FLUSH_START, 63'h7FFF_FFFF_FFFF_FFFF, 24'hFFFFFF, 0);
    send_event(FN_FLUSH_DONE, 63'd5, 24'd0, 0);
    send_event(FN_WAIT_START, 63'd10, 24'd0, 0);
    send_event(FN_WAIT_DONE, 63'd60, 24'd0, 0);
    send_event(FN_WAIT_START, 63'd100, 24'd0, 0);
    send_event(FN_WAIT_DONE, 63'h1_0000_0100, 24'd0, 0);
    send_event(FN_RENDER_START, 63'd500, 24'd0, 0);
    send_event(FN_RENDER_DONE, 63'd400, 24'd0, 0);
    send_event(4'd9, 63'd1, 24'd1, 0);
    send_event(4'd15, 63'h7FFF_FFFF_FFFF_FFFF, 24'hFFFFFF, 0);
    send_event(FN_REPORT, 63'h7FFF_FFFF_FFFF_FFFF, 24'd0, 0);
    // many flushes over one redraw, then no redraws
    for (int i = 0; i < 5; i++) send_event(FN_FLUSH_START, 63'd7, 24'd1, 0);
    send_event(FN_RENDER_DONE, 63'd9, 24'd0, 0);
    send_event(FN_REPORT, 63'd20, 24'd0, 0);

    write_threshold(32'd0);
    send_event(FN_WAIT_START, 63'd30, 24'd0, 0);
    send_event(FN_WAIT_DONE, 63'd30, 24'd0, 0);
    send_event(FN_REPORT, 63'd40, 24'd0, 0);
    write_threshold(32'hFFFF_FFFF);
    clock_us = 63'd1000;

    // sink holds off long while reports keep coming
    hold_req = 1'b1;
    for (int i = 0; i < 4; i++) send_event(FN_REPORT, next_time(), 24'd0, 0);

    sent = 0;
    for (int phase = 0; phase < 4; phase++) begin
      // pause until every expected result has come, then retune
      write_threshold(phase == 0 ? 32'd50 : phase == 1 ? 32'd1 : $urandom_range(0, 300));
      sink_random = (phase != 2);
      for (int k = 0; k < 14; k++) random_frame(phase == 3 ? 0 : 19);
    end
    send_event(FN_REPORT, next_time(), 24'd0, 0);

    wait_drained();
    if (board.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
